>>> rtl/udiv_pkg.sv
`timescale 1ns / 1ps

package udiv_pkg;

  // Operand width used for the division. Port fields stay at PortW bits.
  localparam int WIDTH = 64;
  localparam int PortW = 64;

  typedef struct packed {
    logic [PortW-1:0] dividend;
    logic [PortW-1:0] divisor;
  } div_in_t;

  typedef struct packed {
    logic [PortW-1:0] quotient;
    logic [PortW-1:0] remainder;
    logic             zero_divisor;
  } div_out_t;

  // Per-stage working set. The nq word holds the dividend bits that are
  // still waiting at its top and the quotient bits already formed at its
  // bottom.
  typedef struct packed {
    logic [WIDTH-1:0] part;
    logic [WIDTH-1:0] nq;
    logic [WIDTH-1:0] den;
    logic             zero;
  } stage_t;

endpackage

>>> rtl/udiv_step.sv
`timescale 1ns / 1ps

module udiv_step (
  input  udiv_pkg::stage_t cur_i,
  output udiv_pkg::stage_t nxt_o
);
  import udiv_pkg::*;

  logic             carry;
  logic [WIDTH-1:0] shifted;
  logic [WIDTH+1:0] diff;
  logic             take;

  // One restoring step: shift in the next dividend bit and subtract the
  // divisor when the widened partial remainder is not below it.
  always_comb begin
    carry   = cur_i.part[WIDTH-1];
    shifted = {cur_i.part[WIDTH-2:0], cur_i.nq[WIDTH-1]};
    diff    = {1'b0, carry, shifted} - {2'b00, cur_i.den};
    take    = ~diff[WIDTH+1] & ~cur_i.zero;

    nxt_o.part = take ? diff[WIDTH-1:0] : shifted;
    nxt_o.nq   = {cur_i.nq[WIDTH-2:0], take};
    nxt_o.den  = cur_i.den;
    nxt_o.zero = cur_i.zero;
  end

endmodule

>>> rtl/unsigned_divider_64.sv
`timescale 1ns / 1ps

// Pipelined 64-bit unsigned restoring divider. Each input beat carries a
// dividend and a divisor; each output beat carries the quotient, the
// remainder and a zero_divisor flag. A zero divisor gives quotient 0 and
// remainder 0 with the flag set. The pipeline has WIDTH (64) register
// stages, one quotient bit per stage, and each stage holds one
// WIDTH+2-bit subtract and a select. A new beat is taken every cycle while
// in_stall_o is low, and a result leaves once its beat has passed all the
// stages. Every stage has its own valid bit and loads whenever it is
// empty or its contents move on, so a stall at the output only backs up
// occupied stages; empty slots further up still fill, and the input stalls
// only once the whole pipeline is full.

module unsigned_divider_64 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  udiv_pkg::div_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output udiv_pkg::div_out_t out_data_o
);
  import udiv_pkg::*;

  stage_t             in_stage;
  stage_t             step_in  [1:WIDTH];
  stage_t             step_out [1:WIDTH];
  stage_t             stg_q    [1:WIDTH];
  logic   [WIDTH:1]   v_in;
  logic   [WIDTH:1]   v_q;
  logic   [WIDTH:1]   en;

  // Operands are cut to WIDTH bits. A zero divisor clears the working word
  // so that every step leaves zeros behind.
  always_comb begin
    in_stage.den  = in_data_i.divisor[WIDTH-1:0];
    in_stage.zero = (in_data_i.divisor[WIDTH-1:0] == '0);
    in_stage.part = '0;
    in_stage.nq   = in_stage.zero ? '0 : in_data_i.dividend[WIDTH-1:0];
  end

  // A stage may load when it is empty or when its beat moves on.
  assign en[WIDTH] = ~v_q[WIDTH] | ~out_stall_i;

  for (genvar k = 1; k <= WIDTH; k++) begin : g_stage
    if (k == 1) begin : g_first
      assign step_in[k] = in_stage;
      assign v_in[k]    = in_valid_i;
    end else begin : g_rest
      assign step_in[k] = stg_q[k-1];
      assign v_in[k]    = v_q[k-1];
    end

    if (k < WIDTH) begin : g_en
      assign en[k] = ~v_q[k] | en[k+1];
    end

    udiv_step u_step (
      .cur_i (step_in[k]),
      .nxt_o (step_out[k])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && v_in[k]) begin
        stg_q[k] <= step_out[k];
      end
    end
  end

  assign in_stall_o  = ~en[1];
  assign out_valid_o = v_q[WIDTH];

  always_comb begin
    out_data_o.quotient     = PortW'(stg_q[WIDTH].nq);
    out_data_o.remainder    = PortW'(stg_q[WIDTH].part);
    out_data_o.zero_divisor = stg_q[WIDTH].zero;
  end

endmodule

>>> rtl/udiv_checker.sv
`timescale 1ns / 1ps

module udiv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input udiv_pkg::div_out_t out_data_o
);
  import udiv_pkg::*;

  // A stalled output beat stays valid.
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload.
  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // A division by zero reports zero quotient and remainder.
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_divisor |->
      out_data_o.quotient == '0 && out_data_o.remainder == '0)
    else $error("zero divisor beat with nonzero result");

  // Without back pressure at the output the input never stalls.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled although output is free");

endmodule

bind unsigned_divider_64 udiv_checker u_udiv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> tb/sv/udiv_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the divider, works out the quotient and remainder
// of every accepted input beat and compares them, in order, with the output
// beats.
module udiv_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  udiv_pkg::div_in_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  udiv_pkg::div_out_t out_data_i,
  output int                 mismatch_cnt_o,
  output int                 answers_owed_o
);

  import udiv_pkg::*;

  localparam int ReportLimit = 10;

  div_out_t quotient_fifo[$];

  // Bit-serial long division on a WIDTH-bit partial remainder. The bit
  // shifted out of the top forces the subtract, so large divisors still
  // come out exact.
  function automatic div_out_t restoring_divide(div_in_t ops);
    logic [WIDTH-1:0] num;
    logic [WIDTH-1:0] den;
    logic [WIDTH-1:0] quo;
    logic [WIDTH-1:0] part;
    logic             carry;
    div_out_t         res;
    num  = ops.dividend[WIDTH-1:0];
    den  = ops.divisor[WIDTH-1:0];
    quo  = '0;
    part = '0;
    res  = '0;
    if (den == '0) begin
      res.zero_divisor = 1'b1;
      return res;
    end
    for (int b = WIDTH - 1; b >= 0; b--) begin
      carry = part[WIDTH-1];
      part  = {part[WIDTH-2:0], num[b]};
      if (carry || part >= den) begin
        part   = part - den;
        quo[b] = 1'b1;
      end
    end
    res.quotient[WIDTH-1:0]  = quo;
    res.remainder[WIDTH-1:0] = part;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    div_out_t owed;
    if (!rst_ni) begin
      quotient_fifo.delete();
      mismatch_cnt_o = 0;
      answers_owed_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (quotient_fifo.size() == 0) begin
          if (mismatch_cnt_o < ReportLimit) begin
            $display("%0t: unexpected result beat q=%h r=%h z=%b", $realtime,
                     out_data_i.quotient, out_data_i.remainder,
                     out_data_i.zero_divisor);
          end
          mismatch_cnt_o++;
        end else begin
          owed = quotient_fifo.pop_front();
          if (out_data_i.quotient !== owed.quotient ||
              out_data_i.remainder !== owed.remainder ||
              out_data_i.zero_divisor !== owed.zero_divisor) begin
            if (mismatch_cnt_o < ReportLimit) begin
              $display("%0t: mismatch expected q=%h r=%h z=%b got q=%h r=%h z=%b",
                       $realtime, owed.quotient, owed.remainder, owed.zero_divisor,
                       out_data_i.quotient, out_data_i.remainder,
                       out_data_i.zero_divisor);
            end
            mismatch_cnt_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        quotient_fifo.push_back(restoring_divide(in_data_i));
      end
      answers_owed_o = quotient_fifo.size();
    end
  end

endmodule

>>> tb/sv/tb_unsigned_divider_64.sv
`timescale 1ns / 1ps

// Top of the divider testbench. This module only makes stimulus and gives
// the verdict; the checker instance beside the block predicts every result
// and counts mismatches. Inputs change on the falling clock edge so that the
// block and the checker both see settled values at the rising edge.
module tb_unsigned_divider_64;

  import udiv_pkg::*;

  // The pipeline is 64 stages deep.
  localparam int PipeDepth     = 64;
  localparam int RandomBeats   = 1300;
  localparam int CalmTail      = 150;
  localparam int LongHold      = 200;
  localparam int WatchdogLimit = 4000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall_o;
  div_in_t  operands;
  logic     out_valid_o;
  logic     out_stall;
  div_out_t out_data_o;

  int       mismatch_cnt;
  int       answers_owed;

  // Set by the stimulus to ask the receiver for one long hold-off. Until the
  // receiver marks the hold as done the sender never idles, so the pipeline
  // fills and stalls its input.
  bit       hold_request;
  // Set by the receiver once the long hold-off is over.
  bit       hold_done;
  // In the calm tail of the run neither side idles.
  bit       calm;

  unsigned_divider_64 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (operands),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  udiv_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall_o),
    .in_data_i      (operands),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data_o),
    .mismatch_cnt_o (mismatch_cnt),
    .answers_owed_o (answers_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A 64-bit value whose magnitude is spread over the whole range: half of
  // the time every bit is random, otherwise the value is cut down to a
  // random number of significant bits.
  function automatic logic [63:0] any_magnitude();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) begin
      v = v >> $urandom_range(0, 63);
    end
    return v;
  endfunction

  // Offers one beat at a falling edge and holds it, unchanged, until the
  // block takes it. Afterwards the sender may go quiet for a short burst,
  // except during the long receiver hold and in the calm tail.
  task automatic offer_beat(input logic [63:0] num, input logic [63:0] den);
    operands.dividend = num;
    operands.divisor  = den;
    in_valid          = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (!calm && !(hold_request && !hold_done) && $urandom_range(0, 99) < 10) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
  endtask

  // Receiver side. Stalls come in random bursts with stretches of free
  // flow in between; on request it holds off for a long stretch counted
  // here, so that the whole pipeline backs up.
  initial begin : receiver
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request && !hold_done) begin
        out_stall = 1'b1;
        repeat (LongHold) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 12) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
      out_stall = 1'b0;
      @(negedge clk_i);
    end
  end

  // Ends the run when no beat has moved on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [63:0] num;
    logic [63:0] den;
    int          kind;
    hold_request = 1'b0;
    calm         = 1'b0;
    in_valid     = 1'b0;
    operands     = '0;
    rst_ni       = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed beats: zero divisors, the operand extremes, divisors with the
    // top bit set where the partial remainder overflows, exact division,
    // and dividends below the divisor.
    offer_beat(64'd0, 64'd0);
    offer_beat('1, 64'd0);
    offer_beat(64'hA5A5_5A5A_F0F0_0F0F, 64'd0);
    offer_beat(64'd0, 64'd1);
    offer_beat('1, 64'd1);
    offer_beat('1, '1);
    offer_beat(64'd1, '1);
    offer_beat(64'hFFFF_FFFF_FFFF_FFFE, '1);
    offer_beat('1, 64'h8000_0000_0000_0000);
    offer_beat(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
    offer_beat(64'h8000_0000_0000_0005, 64'h8000_0000_0000_0000);
    offer_beat('1, 64'h7FFF_FFFF_FFFF_FFFF);
    offer_beat('1, 64'h8000_0000_0000_0001);
    offer_beat('1, 64'd2);
    offer_beat(64'h8000_0000_0000_0000, 64'd3);
    offer_beat(64'd12345, 64'd7);
    offer_beat(64'd100, 64'd10);
    offer_beat(64'd7, 64'd100);
    offer_beat(64'd0, '1);
    offer_beat(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    offer_beat(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);

    for (int i = 0; i < RandomBeats; i++) begin
      // One long receiver hold early on, with the sender pushing hard.
      if (i == 300) begin
        hold_request = 1'b1;
      end
      // Later the sender drains the block completely before going on.
      if (i == 700) begin
        in_valid = 1'b0;
        wait (answers_owed == 0);
        @(negedge clk_i);
      end
      if (i == RandomBeats - CalmTail) begin
        calm = 1'b1;
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          num = any_magnitude();
          den = 64'd0;
        end
        1, 2: begin
          num = {$urandom, $urandom};
          den = {$urandom, $urandom};
        end
        3: begin
          num = {$urandom, $urandom};
          den = 64'($urandom_range(1, 1000));
        end
        4: begin
          num = {$urandom, $urandom};
          den = {1'b1, 31'($urandom), $urandom};
        end
        5, 6: begin
          num = any_magnitude();
          den = any_magnitude();
        end
        7: begin
          // Dividend right around the divisor.
          den = any_magnitude();
          num = den + 64'($urandom_range(0, 2)) - 64'd1;
        end
        default: begin
          num = {$urandom, $urandom};
          den = any_magnitude();
        end
      endcase
      offer_beat(num, den);
    end
    in_valid = 1'b0;

    // Let every owed result come out, then give the pipeline time to show
    // any stray beat before the verdict.
    wait (answers_owed == 0);
    repeat (PipeDepth + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && answers_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
